>>> sv/dssm_pkg.sv
// Shared types and constants for the dual stack block.
// Used by the front, queue, back and top level; depends on nothing.
package dssm_pkg;

   localparam int STORE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int WORD_W      = 32;
   localparam int CAP_W       = 7;
   localparam int ACTION_W    = 2;
   localparam int STATUS_W    = 2;
   localparam int CAP_RESET   = (64 > STORE_DEPTH) ? STORE_DEPTH : 64;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_POP  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_PEEK = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_DUMP = 2'd3;

   localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STS_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] STS_EMPTY    = 2'd2;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_STATUS,
      CMD_READ
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type          op;
      logic [ADDR_W-1:0]   addr;
      logic [WORD_W-1:0]   word;
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0]    count;
      logic                down;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_beat_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_READ = 2'b10
   } back_state_type;

endpackage

>>> sv/dssm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package.
module dssm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/dssm_front.sv
// Front end: takes request beats, keeps stack counts and capacity, classifies
// each item into a command for the back end. Depends on dssm_pkg.
module dssm_front import dssm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CAP_W-1:0]         csr_wr_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [ACTION_W-1:0]      req_action,
   input  logic                     req_stack_select,
   input  logic signed [WORD_W-1:0] req_push_value,
   output cmd_beat_type             q_push,
   input  logic                     q_full
);

   logic [CNT_W-1:0] lower_count_ff, lower_count_in;
   logic [CNT_W-1:0] upper_count_ff, upper_count_in;
   logic [CNT_W-1:0] cap_ff, cap_in;
   logic [CNT_W-1:0] cap_wr;
   logic [CNT_W-1:0] sel_count;
   logic [CNT_W:0]   total;
   logic             accept;
   logic             empty;
   cmd_type          cmd;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // clamp the written capacity into 1..STORE_DEPTH
   always_comb begin
      if (csr_wr_data == '0) begin
         cap_wr = CNT_W'(1);
      end else if (int'(csr_wr_data) > STORE_DEPTH) begin
         cap_wr = CNT_W'(STORE_DEPTH);
      end else begin
         cap_wr = CNT_W'(csr_wr_data);
      end
   end

   assign sel_count = req_stack_select ? upper_count_ff : lower_count_ff;
   assign total     = {1'b0, lower_count_ff} + {1'b0, upper_count_ff};
   assign empty     = (sel_count == '0);

   always_comb begin
      cmd.op         = CMD_STATUS;
      cmd.addr       = '0;
      cmd.word       = req_push_value;
      cmd.status     = STS_OK;
      cmd.count      = sel_count;
      cmd.down       = !req_stack_select;
      lower_count_in = lower_count_ff;
      upper_count_in = upper_count_ff;
      cap_in         = cap_ff;

      case (req_action)
         ACT_PUSH: begin
            if (total >= {1'b0, cap_ff}) begin
               cmd.status = STS_OVERFLOW;
            end else begin
               cmd.op = CMD_WRITE;
               if (req_stack_select) begin
                  cmd.addr       = ADDR_W'(cap_ff - upper_count_ff - CNT_W'(1));
                  upper_count_in = upper_count_ff + CNT_W'(1);
               end else begin
                  cmd.addr       = ADDR_W'(lower_count_ff);
                  lower_count_in = lower_count_ff + CNT_W'(1);
               end
            end
         end
         ACT_POP: begin
            if (empty) begin
               cmd.status = STS_EMPTY;
            end else if (req_stack_select) begin
               upper_count_in = upper_count_ff - CNT_W'(1);
            end else begin
               lower_count_in = lower_count_ff - CNT_W'(1);
            end
         end
         ACT_PEEK, ACT_DUMP: begin
            if (empty) begin
               cmd.status = STS_EMPTY;
            end else begin
               cmd.op = CMD_READ;
               if (req_stack_select) begin
                  cmd.addr = ADDR_W'(cap_ff - sel_count);
               end else begin
                  cmd.addr = ADDR_W'(sel_count - CNT_W'(1));
               end
               if (req_action == ACT_PEEK) begin
                  cmd.count = CNT_W'(1);
               end
            end
         end
         default: begin
            cmd.op = CMD_STATUS;
         end
      endcase

      if (!accept) begin
         lower_count_in = lower_count_ff;
         upper_count_in = upper_count_ff;
      end

      // a capacity write empties both stacks
      if (csr_wr_en) begin
         cap_in         = cap_wr;
         lower_count_in = '0;
         upper_count_in = '0;
      end
   end

   assign q_push.valid = accept;
   assign q_push.cmd   = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_count_ff <= '0;
         upper_count_ff <= '0;
         cap_ff         <= CNT_W'(CAP_RESET);
      end else begin
         lower_count_ff <= lower_count_in;
         upper_count_ff <= upper_count_in;
         cap_ff         <= cap_in;
      end
   end

endmodule

>>> sv/dssm_queue.sv
// Short command queue between front and back end.
// Depends on dssm_pkg for the command type and depth.
module dssm_queue import dssm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_beat_type q_push,
   output logic         q_full,
   output cmd_beat_type q_head,
   input  logic         q_pop
);

   cmd_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] ptr);
      if (ptr == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + QPTR_W'(1);
   endfunction

   assign q_full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_head.valid = (count_ff != '0);
   assign q_head.cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = q_push.valid ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = q_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(q_push.valid) - QCNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.valid) begin
         entries_ff[wr_ptr_ff] <= q_push.cmd;
      end
   end

endmodule

>>> sv/dssm_back.sv
// Back end: executes queued commands against the shared RAM and drives the
// registered response beat. Depends on dssm_pkg and dssm_ram.
module dssm_back import dssm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_beat_type             q_head,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [WORD_W-1:0] rsp_value,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic                     rsp_last
);

   back_state_type      state_ff, state_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [CNT_W-1:0]    remain_ff, remain_in;
   logic                down_ff, down_in;
   logic [ADDR_W-1:0]   addr_step;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]   rsp_value_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_last_ff;
   logic                out_free;
   logic                load;
   logic [WORD_W-1:0]   load_value;
   logic [STATUS_W-1:0] load_status;
   logic                load_last;
   logic                wr_en;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic [WORD_W-1:0]   rd_data;

   dssm_ram #(
      .WIDTH(WORD_W),
      .DEPTH(STORE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (q_head.cmd.addr),
      .wr_data (q_head.cmd.word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign addr_step = down_ff ? addr_ff - ADDR_W'(1) : addr_ff + ADDR_W'(1);

   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      remain_in   = remain_ff;
      down_in     = down_ff;
      q_pop       = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = addr_ff;
      load        = 1'b0;
      load_value  = '0;
      load_status = STS_OK;
      load_last   = 1'b1;

      case (state_ff)
         BK_IDLE: begin
            if (q_head.valid) begin
               case (q_head.cmd.op)
                  CMD_WRITE: begin
                     if (out_free) begin
                        q_pop = 1'b1;
                        wr_en = 1'b1;
                        load  = 1'b1;
                     end
                  end
                  CMD_STATUS: begin
                     if (out_free) begin
                        q_pop       = 1'b1;
                        load        = 1'b1;
                        load_status = q_head.cmd.status;
                     end
                  end
                  CMD_READ: begin
                     q_pop     = 1'b1;
                     rd_en     = 1'b1;
                     rd_addr   = q_head.cmd.addr;
                     addr_in   = q_head.cmd.addr;
                     remain_in = q_head.cmd.count;
                     down_in   = q_head.cmd.down;
                     state_in  = BK_READ;
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         BK_READ: begin
            // read data holds while the response side stalls
            if (out_free) begin
               load       = 1'b1;
               load_value = rd_data;
               load_last  = (remain_ff == CNT_W'(1));
               if (remain_ff == CNT_W'(1)) begin
                  state_in = BK_IDLE;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr   = addr_step;
                  addr_in   = addr_step;
                  remain_in = remain_ff - CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      remain_ff <= remain_in;
      down_ff   <= down_in;
      if (load) begin
         rsp_value_ff  <= load_value;
         rsp_status_ff <= load_status;
         rsp_last_ff   <= load_last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

>>> sv/dual_stack_shared_memory.sv
// Two stacks sharing one RAM: lower stack grows up from entry 0, upper stack
// grows down from the capacity in use. Top level; depends on dssm_pkg,
// dssm_front, dssm_queue and dssm_back.
//
// Request channel (req_*): action, stack select and push word, valid/stall.
// Response channel (rsp_*): value, status and last, valid/stall. Push, pop
// and peek give one beat; dump gives one beat per entry, top first, with
// last on the bottom entry; an empty stack gives one empty-status beat.
// csr_wr_en/csr_wr_data set the capacity in use and empty both stacks.
//
// Push/pop results pass the command queue entry, then the output register;
// peek and dump results pass the queue entry, the registered RAM read, then
// the output register. The front takes one request per cycle while the
// two-entry command queue has room. A peek or dump holds the back end in its
// read state, limited by the single registered RAM read port.
// Reset empties both stacks and sets the capacity to 64; there is no RAM
// clearing pass. A stalled response holds its beat; the back end then stops
// and the queue fills, after which req_stall rises.
module dual_stack_shared_memory import dssm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CAP_W-1:0]         csr_wr_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [ACTION_W-1:0]      req_action,
   input  logic                     req_stack_select,
   input  logic signed [WORD_W-1:0] req_push_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [WORD_W-1:0] rsp_value,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic                     rsp_last
);

   cmd_beat_type q_push;
   cmd_beat_type q_head;
   logic         q_full;
   logic         q_pop;

   dssm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_stack_select (req_stack_select),
      .req_push_value   (req_push_value),
      .q_push           (q_push),
      .q_full           (q_full)
   );

   dssm_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_full (q_full),
      .q_head (q_head),
      .q_pop  (q_pop)
   );

   dssm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

`ifndef ASSERT_OFF
   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STS_OK) |-> (rsp_last && rsp_value == '0))
      else $error("error response must be a single zero-valued last beat");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head.valid)
      else $error("back end popped an empty command queue");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push.valid)
      else $error("front end pushed into a full command queue");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
`endif

endmodule

>>> tb/dual_stack_shared_memory_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for dual_stack_shared_memory: a small class tracks both
// stacks and the expected response beats. Depends on dssm_pkg and the top level.
module dual_stack_shared_memory_tb;
   import dssm_pkg::*;

   localparam int HANG_LIMIT = 2000;
   localparam logic [CAP_W-1:0] PHASE_CAPS [8] = '{
      7'd127, 7'd3, 7'd20, 7'd1, 7'd65, 7'd6, 7'd64, 7'd2
   };

   typedef struct packed {
      logic signed [WORD_W-1:0] value;
      logic [STATUS_W-1:0]      status;
      logic                     last;
   } rsp_beat_type;

   class stack_pair_book;
      rsp_beat_type      due_beats[$];
      logic [WORD_W-1:0] words [STORE_DEPTH];
      logic [CAP_W-1:0]  cap;
      logic [CNT_W-1:0]  low_depth;
      logic [CNT_W-1:0]  high_depth;
      int                mismatches;

      function new();
         cap        = CAP_W'(CAP_RESET);
         low_depth  = '0;
         high_depth = '0;
         mismatches = 0;
      endfunction

      // Out-of-range sizes clamp; any write empties both stacks.
      function void set_capacity(logic [CAP_W-1:0] v);
         if (v < 1)
            cap = CAP_W'(1);
         else if (v > STORE_DEPTH)
            cap = CAP_W'(STORE_DEPTH);
         else
            cap = v;
         low_depth  = '0;
         high_depth = '0;
      endfunction

      function int pending();
         return due_beats.size();
      endfunction

      function void add_beat(logic [WORD_W-1:0] v, logic [STATUS_W-1:0] s, logic l);
         due_beats.push_back('{value: v, status: s, last: l});
      endfunction

      function void note_request(logic [ACTION_W-1:0] act, logic upper,
                                 logic [WORD_W-1:0] word);
         int depth;
         int c;
         int addr;
         depth = upper ? int'(high_depth) : int'(low_depth);
         c     = int'(cap);
         case (act)
            ACT_PUSH: begin
               if (int'(low_depth) + int'(high_depth) >= c) begin
                  add_beat('0, STS_OVERFLOW, 1'b1);
               end else begin
                  if (upper) begin
                     high_depth++;
                     words[(c - int'(high_depth)) % STORE_DEPTH] = word;
                  end else begin
                     words[int'(low_depth) % STORE_DEPTH] = word;
                     low_depth++;
                  end
                  add_beat('0, STS_OK, 1'b1);
               end
            end
            ACT_POP: begin
               if (depth == 0) begin
                  add_beat('0, STS_EMPTY, 1'b1);
               end else begin
                  if (upper)
                     high_depth--;
                  else
                     low_depth--;
                  add_beat('0, STS_OK, 1'b1);
               end
            end
            ACT_PEEK: begin
               if (depth == 0) begin
                  add_beat('0, STS_EMPTY, 1'b1);
               end else begin
                  addr = upper ? c - depth : depth - 1;
                  add_beat(words[addr], STS_OK, 1'b1);
               end
            end
            default: begin
               if (depth == 0)
                  add_beat('0, STS_EMPTY, 1'b1);
               // top first, bottom entry carries last
               for (int i = 0; i < depth; i++) begin
                  addr = upper ? c - depth + i : depth - 1 - i;
                  add_beat(words[addr], STS_OK, i + 1 == depth);
               end
            end
         endcase
      endfunction

      function void check_beat(rsp_beat_type got);
         rsp_beat_type want;
         if (due_beats.size() == 0) begin
            $display("%0t: unexpected result beat: value %0d status %0d last %0b",
                     $time, got.value, got.status, got.last);
            mismatches++;
            return;
         end
         want = due_beats.pop_front();
         if (got !== want) begin
            $display({"%0t: result beat mismatch: expected value %0d status %0d last %0b,",
                      " actual value %0d status %0d last %0b"},
                     $time, want.value, want.status, want.last,
                     got.value, got.status, got.last);
            mismatches++;
         end
      endfunction
   endclass

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     csr_wr_en        = 1'b0;
   logic [CAP_W-1:0]         csr_wr_data      = '0;
   logic                     req_valid        = 1'b0;
   logic                     req_stall;
   logic [ACTION_W-1:0]      req_action       = ACT_PUSH;
   logic                     req_stack_select = 1'b0;
   logic signed [WORD_W-1:0] req_push_value   = '0;
   logic                     rsp_valid;
   logic                     rsp_stall        = 1'b0;
   logic signed [WORD_W-1:0] rsp_value;
   logic [STATUS_W-1:0]      rsp_status;
   logic                     rsp_last;

   stack_pair_book book;
   bit             quiet = 1'b0;
   int             hold_left = 0;
   int             hung_cycles = 0;

   dual_stack_shared_memory dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_stack_select (req_stack_select),
      .req_push_value   (req_push_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value        (rsp_value),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int draw_gap();
      return quiet ? 0 : $urandom_range(0, 7);
   endfunction

   // Hold off the response side for a fresh random count after each beat.
   always @(posedge clock) begin
      if (reset) begin
         hold_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            hold_left = draw_gap();
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         book.check_beat(rsp_beat_type'({rsp_value, rsp_status, rsp_last}));
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
         hung_cycles = 0;
      else
         hung_cycles++;
      if (hung_cycles == HANG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Valid stays high after a beat so a back-to-back item needs no second edit.
   task automatic send_item(input logic [ACTION_W-1:0] act, input logic upper,
                            input logic [WORD_W-1:0] word);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_stack_select <= upper;
      req_push_value   <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note_request(act, upper, word);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] v);
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      book.set_capacity(v);
   endtask

   initial begin
      int                  r;
      int                  n;
      logic [ACTION_W-1:0] act;
      book = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty stacks, word extremes, both tops and both dumps at full size
      send_item(ACT_PEEK, 1'b0, 32'h0);
      send_item(ACT_POP,  1'b1, 32'hFFFF_FFFF);
      send_item(ACT_DUMP, 1'b0, 32'h0);
      send_item(ACT_DUMP, 1'b1, 32'h0);
      send_item(ACT_PUSH, 1'b0, 32'h7FFF_FFFF);
      send_item(ACT_PUSH, 1'b0, 32'h8000_0000);
      send_item(ACT_PUSH, 1'b1, 32'h0000_0000);
      send_item(ACT_PUSH, 1'b1, 32'hFFFF_FFFF);
      send_item(ACT_PEEK, 1'b0, 32'h0);
      send_item(ACT_PEEK, 1'b1, 32'h0);
      send_item(ACT_DUMP, 1'b0, 32'h0);
      send_item(ACT_DUMP, 1'b1, 32'h0);
      send_item(ACT_POP,  1'b0, 32'h0);
      send_item(ACT_POP,  1'b1, 32'h0);
      send_item(ACT_PEEK, 1'b0, 32'h0);

      // size zero acts as one entry; the write also empties both stacks
      write_capacity(7'd0);
      send_item(ACT_DUMP, 1'b0, 32'h0);
      send_item(ACT_PUSH, 1'b0, $urandom);
      send_item(ACT_PUSH, 1'b1, $urandom);
      send_item(ACT_PEEK, 1'b0, 32'h0);
      send_item(ACT_POP,  1'b0, 32'h0);
      send_item(ACT_PUSH, 1'b1, 32'h5555_5555);
      send_item(ACT_PUSH, 1'b0, 32'hAAAA_AAAA);
      send_item(ACT_DUMP, 1'b1, 32'h0);
      send_item(ACT_POP,  1'b1, 32'h0);

      for (int p = 0; p < 8; p++) begin
         write_capacity(PHASE_CAPS[p]);
         quiet = ($urandom_range(0, 3) == 0);
         n = (p == 2) ? 30 : 11;
         for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 9);
            if (r < 5)
               act = ACT_PUSH;
            else if (r < 7)
               act = ACT_POP;
            else if (r < 9)
               act = ACT_PEEK;
            else
               act = ACT_DUMP;
            send_item(act, 1'($urandom_range(0, 1)), $urandom);
         end
      end

      // drain, then leave room for any stray beat
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (book.mismatches == 0 && book.pending() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> dual_stack_shared_memory.f
sv/dssm_pkg.sv
sv/dssm_ram.sv
sv/dssm_front.sv
sv/dssm_queue.sv
sv/dssm_back.sv
sv/dual_stack_shared_memory.sv
tb/dual_stack_shared_memory_tb.sv
